[rtl/icd_pkg.sv]
`timescale 1ns / 1ps
package icd_pkg;

  // Default coordinate width and its allowed range
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COORD_BITS_MIN = 4;
  localparam int unsigned COORD_BITS_MAX = 14;

  // Number of triangle vertices; the query point comes after them
  localparam int unsigned NUM_VERTS = 3;

  // Exact determinant width for a given coordinate width
  function automatic int unsigned det_bits(input int unsigned coord_bits);
    return 4 * coord_bits + 3;
  endfunction

  // Output tdata width: flag plus determinant, rounded up to whole bytes
  function automatic int unsigned out_bytes_bits(input int unsigned coord_bits);
    return ((det_bits(coord_bits) + 1 + 7) / 8) * 8;
  endfunction

endpackage

[rtl/icd_lift.sv]
`timescale 1ns / 1ps
// Two stages: differences and lifted squares, then lifted differences.
module icd_lift #(
  parameter int unsigned COORD_BITS = icd_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [8*COORD_BITS-1:0]      coords_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [COORD_BITS:0]   dx_o [icd_pkg::NUM_VERTS],
  output logic signed [COORD_BITS:0]   dy_o [icd_pkg::NUM_VERTS],
  output logic signed [2*COORD_BITS:0] dz_o [icd_pkg::NUM_VERTS]
);
  import icd_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned LW = 2 * COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] xs [NUM_VERTS+1];
  logic signed [COORD_BITS-1:0] ys [NUM_VERTS+1];

  logic              v1_q, v2_q;
  logic              en1, en2;
  logic signed [DW-1:0] dx1_d [NUM_VERTS];
  logic signed [DW-1:0] dy1_d [NUM_VERTS];
  logic signed [DW-1:0] dx1_q [NUM_VERTS];
  logic signed [DW-1:0] dy1_q [NUM_VERTS];
  logic signed [LW-1:0] lift_d [NUM_VERTS+1];
  logic signed [LW-1:0] lift_q [NUM_VERTS+1];
  logic signed [DW-1:0] dx2_q [NUM_VERTS];
  logic signed [DW-1:0] dy2_q [NUM_VERTS];
  logic signed [LW-1:0] dz2_d [NUM_VERTS];
  logic signed [LW-1:0] dz2_q [NUM_VERTS];

  assign en2     = ~v2_q | ready_i;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;
  assign valid_o = v2_q;

  // unpack: vertex k holds x at slot 2k and y at slot 2k+1, query point last
  always_comb begin
    for (int k = 0; k <= NUM_VERTS; k++) begin
      xs[k] = coords_i[2*k*COORD_BITS +: COORD_BITS];
      ys[k] = coords_i[(2*k+1)*COORD_BITS +: COORD_BITS];
    end
  end

  always_comb begin
    for (int k = 0; k <= NUM_VERTS; k++) begin
      lift_d[k] = LW'(xs[k]) * LW'(xs[k]) + LW'(ys[k]) * LW'(ys[k]);
    end
    for (int k = 0; k < NUM_VERTS; k++) begin
      dx1_d[k] = DW'(xs[k]) - DW'(xs[NUM_VERTS]);
      dy1_d[k] = DW'(ys[k]) - DW'(ys[NUM_VERTS]);
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_VERTS; k++) begin
      dz2_d[k] = lift_q[k] - lift_q[NUM_VERTS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
      lift_q <= lift_d;
    end
    if (en2 && v1_q) begin
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      dz2_q <= dz2_d;
    end
  end

  assign dx_o = dx2_q;
  assign dy_o = dy2_q;
  assign dz_o = dz2_q;

endmodule

[rtl/icd_cofactor.sv]
`timescale 1ns / 1ps
// One stage: the three 2x2 minors of rows 1 and 2; row 0 rides along.
module icd_cofactor #(
  parameter int unsigned COORD_BITS = icd_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [COORD_BITS:0]     dx_i [3],
  input  logic signed [COORD_BITS:0]     dy_i [3],
  input  logic signed [2*COORD_BITS:0]   dz_i [3],
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [COORD_BITS:0]     dx0_o,
  output logic signed [COORD_BITS:0]     dy0_o,
  output logic signed [2*COORD_BITS:0]   dz0_o,
  output logic signed [3*COORD_BITS+2:0] c0_o,
  output logic signed [3*COORD_BITS+2:0] c1_o,
  output logic signed [2*COORD_BITS+2:0] c2_o
);

  localparam int unsigned CW = 3 * COORD_BITS + 3;
  localparam int unsigned SW = 2 * COORD_BITS + 3;

  logic                  v_q, en;
  logic signed [CW-1:0]  c0_d, c1_d, c0_q, c1_q;
  logic signed [SW-1:0]  c2_d, c2_q;
  logic signed [COORD_BITS:0]   dx0_q, dy0_q;
  logic signed [2*COORD_BITS:0] dz0_q;

  assign en      = ~v_q | ready_i;
  assign ready_o = en;
  assign valid_o = v_q;

  always_comb begin
    c0_d = CW'(dy_i[1]) * CW'(dz_i[2]) - CW'(dy_i[2]) * CW'(dz_i[1]);
    c1_d = CW'(dx_i[1]) * CW'(dz_i[2]) - CW'(dx_i[2]) * CW'(dz_i[1]);
    c2_d = SW'(dx_i[1]) * SW'(dy_i[2]) - SW'(dx_i[2]) * SW'(dy_i[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      c0_q  <= c0_d;
      c1_q  <= c1_d;
      c2_q  <= c2_d;
      dx0_q <= dx_i[0];
      dy0_q <= dy_i[0];
      dz0_q <= dz_i[0];
    end
  end

  assign c0_o  = c0_q;
  assign c1_o  = c1_q;
  assign c2_o  = c2_q;
  assign dx0_o = dx0_q;
  assign dy0_o = dy0_q;
  assign dz0_o = dz0_q;

endmodule

[rtl/icd_det.sv]
`timescale 1ns / 1ps
// Two stages: row-0 products, then the signed sum and the sign flag.
module icd_det #(
  parameter int unsigned COORD_BITS = icd_pkg::COORD_BITS_DEF,
  parameter int unsigned DET_BITS   = icd_pkg::det_bits(COORD_BITS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [COORD_BITS:0]     dx0_i,
  input  logic signed [COORD_BITS:0]     dy0_i,
  input  logic signed [2*COORD_BITS:0]   dz0_i,
  input  logic signed [3*COORD_BITS+2:0] c0_i,
  input  logic signed [3*COORD_BITS+2:0] c1_i,
  input  logic signed [2*COORD_BITS+2:0] c2_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic                           inside_o,
  output logic signed [DET_BITS-1:0]     det_o
);

  localparam int unsigned TW = 4 * COORD_BITS + 4;

  logic                        v1_q, v2_q, en1, en2;
  logic signed [TW-1:0]        t0_d, t1_d, t2_d, t0_q, t1_q, t2_q;
  logic signed [DET_BITS-1:0]  det_d, det_q;
  logic                        inside_d, inside_q;

  assign en2     = ~v2_q | ready_i;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;
  assign valid_o = v2_q;

  always_comb begin
    t0_d = TW'(dx0_i) * TW'(c0_i);
    t1_d = TW'(dy0_i) * TW'(c1_i);
    t2_d = TW'(dz0_i) * TW'(c2_i);
  end

  // exact value fits DET_BITS, so the wrapped low bits are the result
  always_comb begin
    det_d    = DET_BITS'(t0_q) - DET_BITS'(t1_q) + DET_BITS'(t2_q);
    inside_d = ~det_d[DET_BITS-1] && (det_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      t0_q <= t0_d;
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
    if (en2 && v1_q) begin
      det_q    <= det_d;
      inside_q <= inside_d;
    end
  end

  assign det_o    = det_q;
  assign inside_o = inside_q;

endmodule

[rtl/incircle_determinant_test.sv]
`timescale 1ns / 1ps
// Depth: 5 register stages. Throughput: one item per cycle; every stage advances
// when its successor has room, so bubbles collapse and back pressure stalls
// without loss.
// Reset (rst_ni, async, active low) clears the stage valid bits only;
// datapath registers are not reset.
module incircle_determinant_test #(
  parameter  int unsigned COORD_BITS = icd_pkg::COORD_BITS_DEF,
  localparam int unsigned DET_BITS   = icd_pkg::det_bits(COORD_BITS),
  localparam int unsigned OUT_W      = icd_pkg::out_bytes_bits(COORD_BITS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // fields from bit 0 up: ax, ay, bx, by, cx, cy, px, py (COORD_BITS each)
  input  logic [8*COORD_BITS-1:0] s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // fields from bit 0 up: inside_res (1), det_value (DET_BITS), zero pad
  output logic [OUT_W-1:0]        m_axis_tdata_o
);
  import icd_pkg::*;

  // Stages:
  //   1  dx, dy against the query point; lifted x*x+y*y for all four points
  //   2  dz = lift(vertex) - lift(p)
  //   3  2x2 minors of rows 1 and 2 (two multiplies and a subtract each)
  //   4  row 0 times its minor
  //   5  alternating sum, sign flag (output register)

  logic                          lift_valid, lift_ready;
  logic signed [COORD_BITS:0]    dx [NUM_VERTS];
  logic signed [COORD_BITS:0]    dy [NUM_VERTS];
  logic signed [2*COORD_BITS:0]  dz [NUM_VERTS];

  logic                           cof_valid, cof_ready;
  logic signed [COORD_BITS:0]     dx0, dy0;
  logic signed [2*COORD_BITS:0]   dz0;
  logic signed [3*COORD_BITS+2:0] c0, c1;
  logic signed [2*COORD_BITS+2:0] c2;

  logic                           in_circle;
  logic signed [DET_BITS-1:0]     det;

  icd_lift #(
    .COORD_BITS(COORD_BITS)
  ) u_lift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .coords_i(s_axis_tdata_i),
    .valid_o (lift_valid),
    .ready_i (lift_ready),
    .dx_o    (dx),
    .dy_o    (dy),
    .dz_o    (dz)
  );

  icd_cofactor #(
    .COORD_BITS(COORD_BITS)
  ) u_cofactor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(lift_valid),
    .ready_o(lift_ready),
    .dx_i   (dx),
    .dy_i   (dy),
    .dz_i   (dz),
    .valid_o(cof_valid),
    .ready_i(cof_ready),
    .dx0_o  (dx0),
    .dy0_o  (dy0),
    .dz0_o  (dz0),
    .c0_o   (c0),
    .c1_o   (c1),
    .c2_o   (c2)
  );

  icd_det #(
    .COORD_BITS(COORD_BITS),
    .DET_BITS  (DET_BITS)
  ) u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cof_valid),
    .ready_o (cof_ready),
    .dx0_i   (dx0),
    .dy0_i   (dy0),
    .dz0_i   (dz0),
    .c0_i    (c0),
    .c1_i    (c1),
    .c2_i    (c2),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .inside_o(in_circle),
    .det_o   (det)
  );

  // flag in bit 0, determinant above it, zero fill to the byte boundary
  assign m_axis_tdata_o = OUT_W'({det, in_circle});

`ifndef SYNTHESIS
  // flag must agree with the sign of the determinant it travels with
  a_inside_matches_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (in_circle == (~det[DET_BITS-1] && (det != '0))))
    else $error("inside flag disagrees with determinant sign");

  // input side only stalls when the whole pipe is full and the output is held
  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back pressure");

  // a result left unaccepted keeps the output stage occupied
  a_output_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(det)))
    else $error("pending result lost or changed under stall");
`endif

endmodule

[bench/incircle_determinant_test_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the lifted incircle determinant.
// Input transfers go into a model that computes the exact 4x4 determinant.
// Each output transfer is compared in order against that model.
module incircle_determinant_test_test;

  import icd_pkg::*;

  localparam int unsigned CW    = COORD_BITS_DEF;
  localparam int unsigned DET_W = det_bits(CW);
  localparam int unsigned OUT_W = out_bytes_bits(CW);

  localparam int RAND_ITEMS = 1550;
  // Worst case is about 1600 items, with a long source gap and a long sink
  // stall on every one; the 2 ms limit leaves ample margin for that.
  localparam realtime RUN_LIMIT = 2ms;
  localparam int TAIL_CYCLES = 20;  // pipeline is 5 deep

  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));

  // One query: vertices a, b, c and point p, with ax in the lowest bits
  typedef struct packed {
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] ax;
  } query_t;

  typedef struct {
    bit                      in_circle;
    logic signed [DET_W-1:0] det;
  } incircle_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  query_t           s_item = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  query_t    query_queue[$];   // items not yet offered to the block
  incircle_t det_expected[$];  // predictions awaiting their output transfer

  int  err_count = 0;
  int  sent_cnt  = 0;
  int  in_gap    = 0;
  int  rdy_hold  = 0;
  bit  in_took   = 1'b0;  // input transfer happened at the last rising edge
  logic calm;

  incircle_determinant_test #(.COORD_BITS(CW)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Every third block of 150 items runs with no gaps on either side.
  assign calm = ((sent_cnt / 150) % 3) == 0;

  // Exact determinant, reduced to the 3x3 form relative to p.
  function automatic incircle_t lifted_det(input query_t q);
    longint    vx[3], vy[3], dx[3], dy[3], dz[3];
    longint    ppx, ppy, pz, c0, c1, c2, d;
    incircle_t r;
    vx[0] = q.ax; vy[0] = q.ay;
    vx[1] = q.bx; vy[1] = q.by;
    vx[2] = q.cx; vy[2] = q.cy;
    ppx = q.px;
    ppy = q.py;
    pz  = ppx * ppx + ppy * ppy;
    for (int i = 0; i < 3; i++) begin
      dx[i] = vx[i] - ppx;
      dy[i] = vy[i] - ppy;
      dz[i] = vx[i] * vx[i] + vy[i] * vy[i] - pz;
    end
    c0 = dy[1] * dz[2] - dy[2] * dz[1];
    c1 = dx[1] * dz[2] - dx[2] * dz[1];
    c2 = dx[1] * dy[2] - dx[2] * dy[1];
    d  = dx[0] * c0 - dy[0] * c1 + dz[0] * c2;
    r.in_circle = d > 0;
    r.det       = d[DET_W-1:0];
    return r;
  endfunction

  function automatic query_t mk(input int ax, ay, bx, by, cx, cy, px, py);
    query_t q;
    q.ax = CW'(ax); q.ay = CW'(ay); q.bx = CW'(bx); q.by = CW'(by);
    q.cx = CW'(cx); q.cy = CW'(cy); q.px = CW'(px); q.py = CW'(py);
    return q;
  endfunction

  // Appends one item to the pending list.
  task automatic add_query(input query_t q);
    query_queue.insert(query_queue.size(), q);
  endtask

  function automatic int rnd_in(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return rnd_in(1, 3);
    return rnd_in(8, 40);
  endfunction

  // Corner values: both ends of the range, and -1 and zero.
  function automatic int edge_val();
    case ($urandom_range(3))
      0: return CMIN;
      1: return CMAX;
      2: return -1;
      default: return 0;
    endcase
  endfunction

  // Source side. The next item is offered once the current one is gone.
  always @(negedge clk_i) begin
    if (rst_ni && (in_took || !s_axis_tvalid_i)) begin
      if (in_gap > 0) begin
        in_gap          <= in_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (query_queue.size() > 0) begin
        s_item          <= query_queue.pop_front();
        s_axis_tvalid_i <= 1'b1;
        in_gap          <= calm ? 0 : pick_gap();
        sent_cnt        <= sent_cnt + 1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Sink side: ready high for a run, then a stall of random length.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (calm) begin
        m_axis_tready_i <= 1'b1;
        rdy_hold        <= 0;
      end else if (rdy_hold > 0) begin
        rdy_hold <= rdy_hold - 1;
      end else if (!m_axis_tready_i) begin
        m_axis_tready_i <= 1'b1;
        rdy_hold        <= rnd_in(0, 12);
      end else begin
        m_axis_tready_i <= 1'b0;
        rdy_hold        <= pick_gap();
      end
    end
  end

  // Both ports are checked at the rising edge. Outputs are compared first,
  // then the new input transfer is predicted. The pipeline is several stages
  // deep, so no result can belong to an item taken at the same edge.
  always @(posedge clk_i) begin
    incircle_t               want;
    logic signed [DET_W-1:0] got_det;
    bit                      got_in;
    in_took <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_in  = m_axis_tdata_o[0];
      got_det = m_axis_tdata_o[DET_W:1];
      if (det_expected.size() == 0) begin
        $error("output transfer with no result pending: det_value %0d", got_det);
        err_count++;
      end else begin
        want = det_expected.pop_front();
        if (got_in !== want.in_circle) begin
          $error("inside_res: expected %0d, got %0d", want.in_circle, got_in);
          err_count++;
        end
        if (got_det !== want.det) begin
          $error("det_value: expected %0d, got %0d", want.det, got_det);
          err_count++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      det_expected.insert(det_expected.size(), lifted_det(s_item));
  end

  initial begin
    int     m, ox, oy, rad, jx, jy;
    query_t q;

    // Directed cases
    add_query(mk(0, 0, 0, 0, 0, 0, 0, 0));
    add_query(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    add_query(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    // big counterclockwise triangle with the origin inside its circle
    add_query(mk(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, 0, 0));
    // same triangle clockwise, so the sign flips
    add_query(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, 0, 0));
    // point far outside a small triangle
    add_query(mk(-100, 0, 100, 0, 0, 100, CMAX, CMAX));
    add_query(mk(-100, 0, 100, 0, 0, 100, CMIN, CMIN));
    // point on the circle
    add_query(mk(1, 0, 0, 1, -1, 0, 0, -1));
    add_query(mk(CMAX, 0, 0, CMAX, -CMAX, 0, 0, -CMAX));
    // collinear vertices
    add_query(mk(0, 0, 1, 1, 2, 2, 5, -3));
    add_query(mk(CMIN, CMIN, 0, 0, CMAX, CMAX, CMIN, CMAX));
    // repeated vertices, and the point sitting on a vertex
    add_query(mk(7, -9, 7, -9, 7, -9, 100, 3));
    add_query(mk(10, 20, -30, 5, 0, -40, 10, 20));
    // square corners, which are concyclic
    add_query(mk(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
    // alternating extremes to push the magnitude
    add_query(mk(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
    add_query(mk(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN));
    add_query(mk(CMIN, 0, CMAX, 0, 0, CMAX, 0, CMIN));
    add_query(mk(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX));
    add_query(mk(CMIN, CMIN, CMAX, CMIN, 0, CMAX, 0, 1));
    add_query(mk(-1, -1, -1, -1, -1, -1, -1, -1));

    // Random cases
    for (int n = 0; n < RAND_ITEMS; n++) begin
      m = $urandom_range(9);
      if (m <= 5) begin
        q = query_t'({$urandom(), $urandom(), $urandom()});
      end else if (m <= 7) begin
        // tiny coordinates give many zero and near-zero determinants
        q = mk(rnd_in(-3, 3), rnd_in(-3, 3), rnd_in(-3, 3), rnd_in(-3, 3),
               rnd_in(-3, 3), rnd_in(-3, 3), rnd_in(-3, 3), rnd_in(-3, 3));
      end else if (m == 8) begin
        q = mk(edge_val(), edge_val(), edge_val(), edge_val(),
               edge_val(), edge_val(), edge_val(), edge_val());
      end else begin
        // four points on one circle, with the query nudged by at most one
        ox  = rnd_in(-1000, 1000);
        oy  = rnd_in(-1000, 1000);
        rad = rnd_in(0, 1000);
        jx  = rnd_in(-1, 1);
        jy  = rnd_in(-1, 1);
        q = mk(ox + rad, oy, ox, oy + rad, ox - rad, oy, ox + jx, oy - rad + jy);
      end
      add_query(q);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (query_queue.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (det_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("incircle_determinant_test_test: done, clean");
    end else begin
      $display("incircle_determinant_test_test: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("incircle_determinant_test_test: done, errors");
    $finish;
  end

endmodule
